FILE: rtl/core/rcpmd_pkg.sv
// shared types and constants of the rc pulse to motor drive block
package rcpmd_pkg;

  localparam int unsigned StampW   = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CmpW     = 8;
  localparam int unsigned DirW     = 2;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TotalW   = StampW + CountW;

  typedef enum logic [CmdW-1:0] {
    CMD_RISE = 2'd0,
    CMD_FALL = 2'd1,
    CMD_OVF  = 2'd2
  } cmd_e;

  typedef enum logic [DirW-1:0] {
    DIR_OFF  = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_WIDTH  = 3'd0,
    CFG_MAX_WIDTH  = 3'd1,
    CFG_FWD_THR    = 3'd2,
    CFG_BACK_THR   = 3'd3,
    CFG_NEUTRAL    = 3'd4,
    CFG_LOST_LIMIT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [StampW-1:0] min_width;
    logic [StampW-1:0] max_width;
    logic [StampW-1:0] fwd_thr;
    logic [StampW-1:0] back_thr;
    logic [StampW-1:0] neutral;
    logic [CountW-1:0] lost_limit;
  } cfg_t;

  typedef struct packed {
    logic [StampW-1:0] good_width;
    logic              lost;
  } snap_t;

  localparam cfg_t CfgReset = '{
    min_width:  16'd950,
    max_width:  16'd2075,
    fwd_thr:    16'd1550,
    back_thr:   16'd1450,
    neutral:    16'd1500,
    lost_limit: 8'd3
  };

  localparam logic [StampW-1:0] GoodWidthReset = 16'd1500;
  localparam logic [CountW-1:0] CountMax       = 8'hFF;
  localparam logic [CmpW-1:0]   CmpOff         = 8'hFF;
  localparam logic [CmpW:0]     CmpFull        = 9'd256;

endpackage

FILE: rtl/core/rcpmd_event.sv
// capture event state: rise stamp, overflow count, accepted width, lost flag
module rcpmd_event (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_i,
  input  logic [rcpmd_pkg::CmdW-1:0]   command_i,
  input  logic [rcpmd_pkg::StampW-1:0] timestamp_i,
  input  rcpmd_pkg::cfg_t              cfg_i,
  output rcpmd_pkg::snap_t             snap_o
);

  logic [rcpmd_pkg::StampW-1:0] rise_q, rise_d;
  logic [rcpmd_pkg::CountW-1:0] count_q, count_d, count_inc;
  logic [rcpmd_pkg::StampW-1:0] good_q, good_d;
  logic                         lost_q, lost_d;
  logic [rcpmd_pkg::TotalW-1:0] total, width, rise_ext;
  logic                         in_window;

  assign rise_ext  = {{rcpmd_pkg::CountW{1'b0}}, rise_q};
  assign total     = {count_q, timestamp_i};
  assign width     = total - rise_ext;
  assign in_window = (total >= rise_ext)
                  && (width >= {{rcpmd_pkg::CountW{1'b0}}, cfg_i.min_width})
                  && (width <= {{rcpmd_pkg::CountW{1'b0}}, cfg_i.max_width});
  assign count_inc = (count_q == rcpmd_pkg::CountMax) ? count_q : count_q + 8'd1;

  always_comb begin
    rise_d  = rise_q;
    count_d = count_q;
    good_d  = good_q;
    lost_d  = lost_q;
    case (rcpmd_pkg::cmd_e'(command_i))
      rcpmd_pkg::CMD_RISE: begin
        rise_d  = timestamp_i;
        count_d = '0;
      end
      rcpmd_pkg::CMD_FALL: begin
        if (in_window) begin
          good_d = width[rcpmd_pkg::StampW-1:0];
        end
      end
      rcpmd_pkg::CMD_OVF: begin
        count_d = count_inc;
        lost_d  = count_inc > cfg_i.lost_limit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q  <= '0;
      count_q <= '0;
      good_q  <= rcpmd_pkg::GoodWidthReset;
      lost_q  <= 1'b1;
    end else if (req_i) begin
      rise_q  <= rise_d;
      count_q <= count_d;
      good_q  <= good_d;
      lost_q  <= lost_d;
    end
  end

  assign snap_o = '{good_width: good_d, lost: lost_d};

endmodule

FILE: rtl/core/rcpmd_drive.sv
// motor direction and pwm compare level from a state snapshot
module rcpmd_drive (
  input  rcpmd_pkg::snap_t            snap_i,
  input  rcpmd_pkg::cfg_t             cfg_i,
  output rcpmd_pkg::dir_e             dir_o,
  output logic [rcpmd_pkg::CmpW-1:0]  cmp_o
);

  logic [rcpmd_pkg::StampW-1:0] delta;
  logic [rcpmd_pkg::StampW:0]   half_sum;
  logic [rcpmd_pkg::StampW-1:0] half;
  logic [rcpmd_pkg::CmpW:0]     level_full;
  logic [rcpmd_pkg::CmpW-1:0]   level;

  assign delta = (snap_i.good_width >= cfg_i.neutral) ? snap_i.good_width - cfg_i.neutral
                                                      : cfg_i.neutral - snap_i.good_width;
  assign half_sum   = {1'b0, delta} + 17'd1;
  assign half       = half_sum[rcpmd_pkg::StampW:1];
  assign level_full = rcpmd_pkg::CmpFull - {1'b0, half[rcpmd_pkg::CmpW-1:0]};

  always_comb begin
    if (half == '0) begin
      level = rcpmd_pkg::CmpOff;
    end else if (|half[rcpmd_pkg::StampW-1:rcpmd_pkg::CmpW]) begin
      level = '0;
    end else begin
      level = level_full[rcpmd_pkg::CmpW-1:0];
    end
  end

  always_comb begin
    if (snap_i.lost) begin
      dir_o = rcpmd_pkg::DIR_OFF;
    end else if (snap_i.good_width > cfg_i.fwd_thr) begin
      dir_o = rcpmd_pkg::DIR_FWD;
    end else if (snap_i.good_width < cfg_i.back_thr) begin
      dir_o = rcpmd_pkg::DIR_BACK;
    end else begin
      dir_o = rcpmd_pkg::DIR_OFF;
    end
  end

  assign cmp_o = (dir_o == rcpmd_pkg::DIR_OFF) ? rcpmd_pkg::CmpOff : level;

endmodule

FILE: rtl/core/rc_pulse_to_motor_drive.sv
// top level: rc pulse decoder driving a brushed motor bridge
//
// input channel: one timer event per request (command_i: rising edge, falling
// edge or timer overflow, with timestamp_i), taken when in_valid_i is high and
// in_stall_o is low
// output channel: one drive request per event (direction_o, compare_value_o,
// signal_ok_o, pulse_width_o), taken when out_valid_o is high and out_stall_i
// is low
// config channel: cfg_index_i selects min width, max width, forward
// threshold, backward threshold, neutral width or lost overflow limit; always
// ready, write only while no request is in flight
// pipeline: the event snapshot is registered into the middle stage at accept, then into the output register
// throughput: 1 event per cycle while out_stall_i is low; event state updates at accept, the drive
// stage and output register follow
// reset: config returns to defaults, signal is reported lost, width 1500
// receiver stall: the output request holds, the middle stage holds, and
// in_stall_o rises once both are full
module rc_pulse_to_motor_drive (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rcpmd_pkg::CmdW-1:0]      command_i,
  input  logic [rcpmd_pkg::StampW-1:0]    timestamp_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rcpmd_pkg::DirW-1:0]      direction_o,
  output logic [rcpmd_pkg::CmpW-1:0]      compare_value_o,
  output logic                            signal_ok_o,
  output logic [rcpmd_pkg::StampW-1:0]    pulse_width_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcpmd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcpmd_pkg::CfgDataW-1:0]  cfg_data_i
);

  rcpmd_pkg::cfg_t  cfg_q;
  rcpmd_pkg::snap_t snap, s1_q;
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             out_load, accept;
  rcpmd_pkg::dir_e  dir, dir_q;
  logic [rcpmd_pkg::CmpW-1:0]   cmp, cmp_q;
  logic                         ok_q;
  logic [rcpmd_pkg::StampW-1:0] width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rcpmd_pkg::CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rcpmd_pkg::cfg_idx_e'(cfg_index_i))
        rcpmd_pkg::CFG_MIN_WIDTH:  cfg_q.min_width  <= cfg_data_i;
        rcpmd_pkg::CFG_MAX_WIDTH:  cfg_q.max_width  <= cfg_data_i;
        rcpmd_pkg::CFG_FWD_THR:    cfg_q.fwd_thr    <= cfg_data_i;
        rcpmd_pkg::CFG_BACK_THR:   cfg_q.back_thr   <= cfg_data_i;
        rcpmd_pkg::CFG_NEUTRAL:    cfg_q.neutral    <= cfg_data_i;
        rcpmd_pkg::CFG_LOST_LIMIT: cfg_q.lost_limit <= cfg_data_i[rcpmd_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign accept     = in_valid_i && !in_stall_o;

  rcpmd_event u_event (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (accept),
    .command_i   (command_i),
    .timestamp_i (timestamp_i),
    .cfg_i       (cfg_q),
    .snap_o      (snap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= snap;
    end
  end

  rcpmd_drive u_drive (
    .snap_i (s1_q),
    .cfg_i  (cfg_q),
    .dir_o  (dir),
    .cmp_o  (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      dir_q   <= dir;
      cmp_q   <= cmp;
      ok_q    <= !s1_q.lost;
      width_q <= s1_q.good_width;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign direction_o     = dir_q;
  assign compare_value_o = cmp_q;
  assign signal_ok_o     = ok_q;
  assign pulse_width_o   = width_q;

  a_off_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (direction_o == rcpmd_pkg::DIR_OFF) |-> compare_value_o == rcpmd_pkg::CmpOff)
    else $error("drive off without idle compare level");

  a_lost_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !signal_ok_o |-> direction_o == rcpmd_pkg::DIR_OFF)
    else $error("drive active while signal lost");

  a_fwd_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (direction_o == rcpmd_pkg::DIR_FWD) |-> pulse_width_o > cfg_q.fwd_thr)
    else $error("forward drive below threshold");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q)
    else $error("middle stage request lost under stall");

endmodule
